// ----- sv/prs80_pkg.sv -----
// PRESENT-80 shared definitions: S-box tables, bit permutations, key schedule steps
// and the per-stage pipeline item type.
// No dependencies.
package prs80_pkg;

  localparam int unsigned NumRounds  = 31;
  localparam int unsigned BlockW     = 64;
  localparam int unsigned KeyW       = 80;
  localparam int unsigned RndW       = 5;
  localparam int unsigned NumNibbles = BlockW / 4;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } prs80_op_e;

  typedef struct packed {
    prs80_op_e         op;
    logic [BlockW-1:0] state;
    logic [KeyW-1:0]   key;
  } prs80_item_t;

  function automatic logic [3:0] sbox_fwd(input logic [3:0] x);
    logic [3:0] y;
    unique case (x)
      4'h0: y = 4'hC;
      4'h1: y = 4'h5;
      4'h2: y = 4'h6;
      4'h3: y = 4'hB;
      4'h4: y = 4'h9;
      4'h5: y = 4'h0;
      4'h6: y = 4'hA;
      4'h7: y = 4'hD;
      4'h8: y = 4'h3;
      4'h9: y = 4'hE;
      4'hA: y = 4'hF;
      4'hB: y = 4'h8;
      4'hC: y = 4'h4;
      4'hD: y = 4'h7;
      4'hE: y = 4'h1;
      default: y = 4'h2;
    endcase
    return y;
  endfunction

  function automatic logic [3:0] sbox_rev(input logic [3:0] x);
    logic [3:0] y;
    unique case (x)
      4'h0: y = 4'h5;
      4'h1: y = 4'hE;
      4'h2: y = 4'hF;
      4'h3: y = 4'h8;
      4'h4: y = 4'hC;
      4'h5: y = 4'h1;
      4'h6: y = 4'h2;
      4'h7: y = 4'hD;
      4'h8: y = 4'hB;
      4'h9: y = 4'h4;
      4'hA: y = 4'h6;
      4'hB: y = 4'h3;
      4'hC: y = 4'h0;
      4'hD: y = 4'h7;
      4'hE: y = 4'h9;
      default: y = 4'hA;
    endcase
    return y;
  endfunction

  function automatic logic [BlockW-1:0] sub_fwd(input logic [BlockW-1:0] v);
    logic [BlockW-1:0] r;
    for (int n = 0; n < NumNibbles; n++) begin
      r[4*n +: 4] = sbox_fwd(v[4*n +: 4]);
    end
    return r;
  endfunction

  function automatic logic [BlockW-1:0] sub_rev(input logic [BlockW-1:0] v);
    logic [BlockW-1:0] r;
    for (int n = 0; n < NumNibbles; n++) begin
      r[4*n +: 4] = sbox_rev(v[4*n +: 4]);
    end
    return r;
  endfunction

  // bit i moves to bit 16*i mod 63, top bit stays
  function automatic logic [BlockW-1:0] perm_fwd(input logic [BlockW-1:0] v);
    logic [BlockW-1:0] r;
    r[BlockW-1] = v[BlockW-1];
    for (int i = 0; i < BlockW - 1; i++) begin
      r[16 * (i & 3) + (i >> 2)] = v[i];
    end
    return r;
  endfunction

  // bit i moves to bit 4*i mod 63, top bit stays
  function automatic logic [BlockW-1:0] perm_rev(input logic [BlockW-1:0] v);
    logic [BlockW-1:0] r;
    r[BlockW-1] = v[BlockW-1];
    for (int i = 0; i < BlockW - 1; i++) begin
      r[4 * (i & 15) + (i >> 4)] = v[i];
    end
    return r;
  endfunction

  // rotate left 61, S-box the top nibble, fold in the round counter
  function automatic logic [KeyW-1:0] key_fwd(input logic [KeyW-1:0] k,
                                              input logic [RndW-1:0] rnd);
    logic [KeyW-1:0] t;
    t = {k[18:0], k[79:19]};
    t[79:76] = sbox_fwd(t[79:76]);
    t[19:15] = t[19:15] ^ rnd;
    return t;
  endfunction

  function automatic logic [KeyW-1:0] key_rev(input logic [KeyW-1:0] k,
                                              input logic [RndW-1:0] rnd);
    logic [KeyW-1:0] t;
    t = k;
    t[19:15] = t[19:15] ^ rnd;
    t[79:76] = sbox_rev(t[79:76]);
    return {t[60:0], t[79:61]};
  endfunction

endpackage

// ----- sv/prs80_key_sched.sv -----
// PRESENT-80 last-round key unit: walks the schedule 31 steps, one per cycle,
// to give the starting key for decryption. Depends on prs80_pkg.
module prs80_key_sched import prs80_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [KeyW-1:0] key_i,
  output logic [KeyW-1:0] key_last_o,
  output logic            ready_o
);

  logic            start_q;
  logic            busy_q, busy_d;
  logic [RndW-1:0] cnt_q, cnt_d;
  logic [KeyW-1:0] key_q, key_d;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    key_d  = key_q;
    if (start_q) begin
      busy_d = 1'b1;
      cnt_d  = RndW'(1);
      key_d  = key_i;
    end else if (busy_q) begin
      key_d = key_fwd(key_q, cnt_q);
      cnt_d = cnt_q + RndW'(1);
      if (cnt_q == RndW'(NumRounds)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
      busy_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      start_q <= start_i;
      busy_q  <= busy_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_last_o = key_q;
  assign ready_o    = ~start_q & ~busy_q;

endmodule

// ----- sv/prs80_round.sv -----
// PRESENT-80 round stage: one encryption or decryption round with its key step,
// behind a registered valid/ready slot. Depends on prs80_pkg.
module prs80_round import prs80_pkg::*; #(
  parameter int unsigned Round = 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  prs80_item_t item_i,
  output logic        valid_o,
  input  logic        ready_i,
  output prs80_item_t item_o
);

  localparam logic [RndW-1:0] EncRnd = RndW'(Round);
  localparam logic [RndW-1:0] DecRnd = RndW'(NumRounds + 1 - Round);

  logic            valid_q;
  prs80_item_t     item_q, item_d;
  logic [KeyW-1:0] key_dec;

  always_comb begin
    key_dec   = key_rev(item_i.key, DecRnd);
    item_d.op = item_i.op;
    unique case (item_i.op)
      OP_ENCRYPT: begin
        item_d.state = perm_fwd(sub_fwd(item_i.state ^ item_i.key[KeyW-1 -: BlockW]));
        item_d.key   = key_fwd(item_i.key, EncRnd);
      end
      OP_DECRYPT: begin
        item_d.state = sub_rev(perm_rev(item_i.state)) ^ key_dec[KeyW-1 -: BlockW];
        item_d.key   = key_dec;
      end
      default: begin
        item_d.state = item_i.state;
        item_d.key   = item_i.key;
      end
    endcase
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- sv/present80_block_cipher.sv -----
// PRESENT-80 block cipher top level: key registers on the APB port, input slot,
// 31 round stages and output register. Depends on prs80_pkg, prs80_round, prs80_key_sched.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries kind_i (0 encrypt, 1 decrypt) and a
//   64-bit block on data_in_i; output channel (out_valid_o/out_ready_i) returns the
//   result on data_out_o, in order, one per input transfer.
//   key_high (bits 79..64) sits at byte address 0, key_low (bits 63..0) at address 8.
//   The result becomes valid after passing the input slot, the 31 round stages and the
//   output register, one round per stage.
//   Throughput: one block per cycle while in_ready_o is high, set by the one-round-per-stage pipeline.
//   The decryption start key is walked through the schedule one step per cycle, so
//   after reset and after each key write in_ready_o stays low until the walk ends.
//   Reset clears both key registers to zero and empties the pipeline.
//   When the receiver stalls, each stage holds its item and bubbles close up; input
//   stops only once every stage is full.
module present80_block_cipher import prs80_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [BlockW-1:0] data_in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BlockW-1:0] data_out_o
);

  typedef enum logic {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } prs80_reg_e;

  logic [15:0]       key_high_q;
  logic [63:0]       key_low_q;
  logic              cfg_wr;
  prs80_reg_e        reg_sel;
  logic [KeyW-1:0]   key_last;
  logic              key_ready;

  assign pready  = 1'b1;
  assign reg_sel = prs80_reg_e'(paddr[3]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_KEY_HIGH: key_high_q <= pwdata[15:0];
        REG_KEY_LOW:  key_low_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_KEY_HIGH: prdata = {48'd0, key_high_q};
      REG_KEY_LOW:  prdata = key_low_q;
      default:      prdata = '0;
    endcase
  end

  prs80_key_sched u_key_sched (
    .clk_i,
    .rst_ni,
    .start_i    (cfg_wr),
    .key_i      ({key_high_q, key_low_q}),
    .key_last_o (key_last),
    .ready_o    (key_ready)
  );

  // input slot: decryption starts from the last round key and takes its XOR here
  logic                valid_s [NumRounds+1];
  logic                ready_s [NumRounds+1];
  prs80_item_t         item_s  [NumRounds+1];
  logic                in_valid_q;
  prs80_item_t         in_item_q, in_item_d;
  logic                in_slot_free;

  assign in_slot_free = ~in_valid_q | ready_s[0];
  assign in_ready_o   = key_ready & in_slot_free;

  always_comb begin
    in_item_d.op = prs80_op_e'(kind_i);
    unique case (prs80_op_e'(kind_i))
      OP_ENCRYPT: begin
        in_item_d.key   = {key_high_q, key_low_q};
        in_item_d.state = data_in_i;
      end
      OP_DECRYPT: begin
        in_item_d.key   = key_last;
        in_item_d.state = data_in_i ^ key_last[KeyW-1 -: BlockW];
      end
      default: begin
        in_item_d.key   = key_last;
        in_item_d.state = data_in_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_slot_free) begin
      in_valid_q <= in_valid_i & key_ready;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_d;
    end
  end

  assign valid_s[0] = in_valid_q;
  assign item_s[0]  = in_item_q;

  for (genvar r = 1; r <= NumRounds; r++) begin : g_round
    prs80_round #(
      .Round (r)
    ) u_round (
      .clk_i,
      .rst_ni,
      .valid_i (valid_s[r-1]),
      .ready_o (ready_s[r-1]),
      .item_i  (item_s[r-1]),
      .valid_o (valid_s[r]),
      .ready_i (ready_s[r]),
      .item_o  (item_s[r])
    );
  end

  // output register: encryption takes the final key XOR
  logic              out_valid_q;
  logic [BlockW-1:0] out_data_q, out_data_d;
  prs80_item_t       last_item;

  assign last_item           = item_s[NumRounds];
  assign ready_s[NumRounds]  = ~out_valid_q | out_ready_i;

  always_comb begin
    unique case (last_item.op)
      OP_ENCRYPT: out_data_d = last_item.state ^ last_item.key[KeyW-1 -: BlockW];
      OP_DECRYPT: out_data_d = last_item.state;
      default:    out_data_d = last_item.state;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_s[NumRounds]) begin
      out_valid_q <= valid_s[NumRounds];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_s[NumRounds] && valid_s[NumRounds]) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_data_q;

endmodule

// ----- tb/sv/present80_block_cipher_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for present80_block_cipher: encrypts and decrypts blocks under several
// keys and idle patterns and checks every result in order against its own PRESENT-80 model.
// Depends on prs80_pkg (operation enum, block width) and the cipher RTL.
module present80_block_cipher_test import prs80_pkg::*; ();

  localparam logic [3:0]  KEY_HIGH_ADDR = 4'h0;
  localparam logic [3:0]  KEY_LOW_ADDR  = 4'h8;
  localparam logic [63:0] SBOX_FWD      = 64'h2174_8FE3_DA09_B65C;
  localparam logic [63:0] SBOX_REV      = 64'hA970_364B_D21C_8FE5;
  localparam int          DRAIN_CYCLES  = 40;
  localparam int          RAND_BLOCKS   = 110;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [3:0]        paddr       = '0;
  logic [63:0]       pwdata      = '0;
  logic [63:0]       prdata;
  logic              pready;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic              kind_i      = 1'b0;
  logic [BlockW-1:0] data_in_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [BlockW-1:0] data_out_o;

  logic [15:0] key_hi_q = '0;
  logic [63:0] key_lo_q = '0;
  logic [63:0] expected_blocks [$];
  int          fail_cnt       = 0;
  int          send_idle_pct  = 0;
  int          stall_pct      = 0;
  int          hold_left      = 0;

  present80_block_cipher i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .data_in_i  (data_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .data_out_o (data_out_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [63:0] substitute(input logic [63:0] v, input logic [63:0] box);
    logic [63:0] r;
    for (int n = 0; n < 16; n++) begin
      r[4*n +: 4] = box[{v[4*n +: 4], 2'b00} +: 4];
    end
    return r;
  endfunction

  function automatic logic [63:0] spread(input logic [63:0] v, input int mul);
    logic [63:0] r;
    r[63] = v[63];
    for (int i = 0; i < 63; i++) begin
      r[(mul * i) % 63] = v[i];
    end
    return r;
  endfunction

  function automatic logic [63:0] present_block(input prs80_op_e op, input logic [63:0] blk);
    logic [79:0] k;
    logic [63:0] rk [32];
    logic [63:0] s;
    k = {key_hi_q, key_lo_q};
    for (int r = 0; r < 32; r++) begin
      rk[r] = k[79:16];
      k = (k << 61) | (k >> 19);
      k[79:76] = SBOX_FWD[{k[79:76], 2'b00} +: 4];
      k[19:15] = k[19:15] ^ 5'(r + 1);
    end
    s = blk;
    if (op == OP_ENCRYPT) begin
      for (int r = 0; r < 31; r++) begin
        s = spread(substitute(s ^ rk[r], SBOX_FWD), 16);
      end
      s = s ^ rk[31];
    end else begin
      s = s ^ rk[31];
      for (int r = 30; r >= 0; r--) begin
        s = substitute(spread(s, 4), SBOX_REV) ^ rk[r];
      end
    end
    return s;
  endfunction

  // check each result transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_blocks.size() == 0) begin
          $error("data_out: unexpected result %h", data_out_o);
          fail_cnt++;
        end else begin
          if (data_out_o !== expected_blocks[0]) begin
            $error("data_out: expected %h, got %h", expected_blocks[0], data_out_o);
            fail_cnt++;
          end
          expected_blocks.delete(0);
        end
      end
    end
  end

  // stall the receiver at random, or for a counted stretch
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_block(input prs80_op_e op, input logic [63:0] blk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= op;
    data_in_i  <= blk;
    do @(posedge clk_i); while (!in_ready_o);
    expected_blocks.push_back(present_block(op, blk));
  endtask

  task automatic settle_pipe();
    in_valid_i <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_key_reg(input logic [3:0] addr, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == KEY_HIGH_ADDR) begin
      key_hi_q = value[15:0];
    end else begin
      key_lo_q = value;
    end
    @(posedge clk_i);
  endtask

  task automatic send_random_block();
    logic [63:0] blk;
    case ($urandom_range(9))
      0: blk = '0;
      1: blk = '1;
      default: blk = {$urandom, $urandom};
    endcase
    send_block(prs80_op_e'($urandom_range(1)), blk);
  endtask

  task automatic test_zero_key();
    send_block(OP_ENCRYPT, 64'h0);
    send_block(OP_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block(OP_ENCRYPT, 64'h5555_5555_5555_5555);
    send_block(OP_ENCRYPT, 64'hAAAA_AAAA_AAAA_AAAA);
    send_block(OP_DECRYPT, 64'h0);
    send_block(OP_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block(OP_DECRYPT, 64'h8000_0000_0000_0000);
    send_block(OP_ENCRYPT, 64'h0000_0000_0000_0001);
    settle_pipe();
  endtask

  task automatic test_key_extremes();
    write_key_reg(KEY_HIGH_ADDR, 64'hFFFF_FFFF_FFFF_FFFF);
    write_key_reg(KEY_LOW_ADDR, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block(OP_ENCRYPT, 64'h0);
    send_block(OP_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block(OP_DECRYPT, 64'h0);
    send_block(OP_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
    settle_pipe();
    // upper bits of key_high are dropped
    write_key_reg(KEY_HIGH_ADDR, 64'hFFFF_FFFF_FFFF_0000);
    write_key_reg(KEY_LOW_ADDR, 64'h0);
    send_block(OP_ENCRYPT, 64'h0);
    send_block(OP_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block(OP_ENCRYPT, 64'h0123_4567_89AB_CDEF);
    send_block(OP_DECRYPT, 64'hFEDC_BA98_7654_3210);
    settle_pipe();
    write_key_reg(KEY_HIGH_ADDR, 64'h0000_0000_0000_8001);
    write_key_reg(KEY_LOW_ADDR, 64'h8000_0000_0000_0001);
    send_block(OP_ENCRYPT, 64'h0);
    send_block(OP_DECRYPT, 64'h0);
    settle_pipe();
  endtask

  task automatic test_idle_phases();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 66; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 66; end
        default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
      write_key_reg(KEY_HIGH_ADDR, {$urandom, $urandom});
      write_key_reg(KEY_LOW_ADDR, {$urandom, $urandom});
      repeat (RAND_BLOCKS) send_random_block();
      settle_pipe();
    end
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  task automatic test_backpressure();
    write_key_reg(KEY_HIGH_ADDR, {$urandom, $urandom});
    write_key_reg(KEY_LOW_ADDR, {$urandom, $urandom});
    hold_left = 300;
    repeat (70) send_random_block();
    settle_pipe();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_key();
    test_key_extremes();
    test_idle_phases();
    test_backpressure();
    settle_pipe();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("present80_block_cipher_test: PASS");
    end else begin
      $display("present80_block_cipher_test: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("present80_block_cipher_test: FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
sv/prs80_pkg.sv
sv/prs80_key_sched.sv
sv/prs80_round.sv
sv/present80_block_cipher.sv
tb/sv/present80_block_cipher_test.sv
